// ===== hw/rtl/fds_pkg.sv =====
// ----------------------------------------------------------------------------
// fds_pkg: shared types and constants of the forth data stack unit
// action codes, status codes, need/nout tables and the front-to-back item
// ----------------------------------------------------------------------------
package fds_pkg;

	localparam int unsigned ACTION_W = 5;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_PUSH   = 5'd0;
	localparam logic [ACTION_W-1:0] ACT_DROP   = 5'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK   = 5'd2;
	localparam logic [ACTION_W-1:0] ACT_DUP    = 5'd3;
	localparam logic [ACTION_W-1:0] ACT_SWAP   = 5'd4;
	localparam logic [ACTION_W-1:0] ACT_OVER   = 5'd5;
	localparam logic [ACTION_W-1:0] ACT_ROT    = 5'd6;
	localparam logic [ACTION_W-1:0] ACT_2SWAP  = 5'd7;
	localparam logic [ACTION_W-1:0] ACT_2DUP   = 5'd8;
	localparam logic [ACTION_W-1:0] ACT_2OVER  = 5'd9;
	localparam logic [ACTION_W-1:0] ACT_ADD    = 5'd10;
	localparam logic [ACTION_W-1:0] ACT_SUB    = 5'd11;
	localparam logic [ACTION_W-1:0] ACT_MUL    = 5'd12;
	localparam logic [ACTION_W-1:0] ACT_DIV    = 5'd13;
	localparam logic [ACTION_W-1:0] ACT_MOD    = 5'd14;
	localparam logic [ACTION_W-1:0] ACT_DIVMOD = 5'd15;
	localparam logic [ACTION_W-1:0] ACT_EQ     = 5'd16;
	localparam logic [ACTION_W-1:0] ACT_LT     = 5'd17;
	localparam logic [ACTION_W-1:0] ACT_GT     = 5'd18;
	localparam logic [ACTION_W-1:0] ACT_INVERT = 5'd19;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

	// register index; byte address is the index times four
	localparam logic [0:0] REG_STACK_LIMIT = 1'd0;

	// class of work the back end does for an item
	typedef enum logic [2:0] {
		CLS_NOP   = 3'd0,
		CLS_SHUF  = 3'd1,
		CLS_ALU   = 3'd2,
		CLS_MUL   = 3'd3,
		CLS_DIV   = 3'd4
	} op_class_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [WORD_W-1:0]   push_value;
		op_class_t           op_class;
		logic                known;
		logic [2:0]          need;
		logic [2:0]          grow_up;   // entries added, zero if shrinking
		logic [2:0]          nout;      // entries written back
	} front_item_t;

	function automatic logic [2:0] need_of(input logic [ACTION_W-1:0] a);
		logic [2:0] n;
		n = 3'd2;
		case (a)
			ACT_PUSH: n = 3'd0;
			ACT_DROP, ACT_PEEK, ACT_DUP, ACT_INVERT: n = 3'd1;
			ACT_ROT: n = 3'd3;
			ACT_2SWAP, ACT_2OVER: n = 3'd4;
			default: n = 3'd2;
		endcase
		return n;
	endfunction

	function automatic logic [2:0] nout_of(input logic [ACTION_W-1:0] a);
		logic [2:0] n;
		n = 3'd1;
		case (a)
			ACT_PUSH, ACT_PEEK, ACT_INVERT: n = 3'd1;
			ACT_DROP: n = 3'd0;
			ACT_DUP, ACT_SWAP, ACT_DIVMOD: n = 3'd2;
			ACT_OVER, ACT_ROT: n = 3'd3;
			ACT_2SWAP, ACT_2DUP: n = 3'd4;
			ACT_2OVER: n = 3'd6;
			default: n = 3'd1;
		endcase
		return n;
	endfunction

endpackage

// ===== hw/rtl/forth_data_stack_unit.sv =====
// ----------------------------------------------------------------------------
// forth_data_stack_unit: bounded forth data stack with decoupled execution
// a decode front and an execution back, joined by a two-entry queue
// ----------------------------------------------------------------------------
// channel  | handshake       | payload
// input    | push / full     | action, push_value
// result   | pop / empty     | status, top_word, depth
// config   | apb psel/penable| stack_limit at address 0
//
// an item runs read, calc, write, top and out from acceptance to result; read
// is skipped if nothing is read; multiply and divide wait, divide on the
// bit-serial divider; underflow, overflow, unknown and div by zero skip to top
// reset clears the count, sets the limit to 64; store contents need no clearing
// full rises when both entries of the decode queue are occupied
// the back end holds one finished result until it is popped
module forth_data_stack_unit #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [4:0]                        action,
	input  logic signed [31:0]                push_value,
	output logic                              empty,
	input  logic                              pop,
	output logic [1:0]                        status,
	output logic signed [31:0]                top_word,
	output logic [6:0]                        depth,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	logic                 q_valid, q_take, res_valid, idle;
	fds_pkg::front_item_t q_item;
	logic [6:0]           limit_q;
	logic [31:0]          top_raw;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == {fds_pkg::REG_STACK_LIMIT, 2'b00}) ? {25'd0, limit_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= 7'd64;
		else if (psel && penable && pwrite && paddr == {fds_pkg::REG_STACK_LIMIT, 2'b00})
			limit_q <= pwdata[6:0];
	end

	fds_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.action(action), .push_value(push_value),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take)
	);

	fds_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .stack_limit(limit_q),
		.q_valid(q_valid), .q_item(q_item), .q_take(q_take),
		.res_valid(res_valid), .res_take(pop),
		.res_status(status), .res_top(top_raw), .res_depth(depth),
		.idle(idle)
	);

	assign empty    = !res_valid;
	assign top_word = top_raw;

	// a result never shows while the back end is still idle with nothing queued
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> empty) else $error("idle with result pending");
	// a popped result is gone on the next edge
	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |=> empty) else $error("result repeated");
	// depth never exceeds the store
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ({25'd0, depth} <= 32'(STACK_DEPTH))) else $error("depth beyond store");
endmodule

// ===== hw/rtl/fds_front.sv =====
// ----------------------------------------------------------------------------
// fds_front: item intake and decode
// classifies each action and pushes it into a small queue for the back end
// ----------------------------------------------------------------------------
module fds_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [fds_pkg::ACTION_W-1:0]      action,
	input  logic signed [fds_pkg::WORD_W-1:0] push_value,
	output logic                              q_valid,
	output fds_pkg::front_item_t              q_item,
	input  logic                              q_take
);
	fds_pkg::front_item_t mem_q [2];
	logic                 wr_q, rd_q;
	logic [1:0]           cnt_q;
	fds_pkg::front_item_t dec;
	logic [2:0]           nd, no;

	always_comb begin
		nd = fds_pkg::need_of(action);
		no = fds_pkg::nout_of(action);
		dec.action     = action;
		dec.push_value = push_value;
		dec.known      = (action <= fds_pkg::ACT_INVERT);
		dec.need       = nd;
		dec.nout       = no;
		dec.grow_up    = (no > nd) ? no - nd : 3'd0;
		case (action)
			fds_pkg::ACT_ADD, fds_pkg::ACT_SUB, fds_pkg::ACT_EQ,
			fds_pkg::ACT_LT, fds_pkg::ACT_GT, fds_pkg::ACT_INVERT:
				dec.op_class = fds_pkg::CLS_ALU;
			fds_pkg::ACT_MUL: dec.op_class = fds_pkg::CLS_MUL;
			fds_pkg::ACT_DIV, fds_pkg::ACT_MOD, fds_pkg::ACT_DIVMOD:
				dec.op_class = fds_pkg::CLS_DIV;
			default: dec.op_class = dec.known ? fds_pkg::CLS_SHUF : fds_pkg::CLS_NOP;
		endcase
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (q_take && q_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, (push && !full)} - {1'b0, (q_take && q_valid)};
		end
	end
endmodule

// ===== hw/rtl/fds_divider.sv =====
// ----------------------------------------------------------------------------
// fds_divider: signed truncating divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module fds_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fds_pkg::WORD_W-1:0]   dividend,
	input  logic [fds_pkg::WORD_W-1:0]   divisor,
	output logic                         done,
	output logic [fds_pkg::WORD_W-1:0]   quot,
	output logic [fds_pkg::WORD_W-1:0]   rem
);
	localparam int unsigned W = fds_pkg::WORD_W;
	logic [W-1:0] q_q, r_q, d_q;
	logic         nq_q, nr_q, busy_q;
	logic [5:0]   n_q;
	logic [W:0]   trial;
	logic [W-1:0] rs;

	assign rs    = {r_q[W-2:0], q_q[W-1]};
	assign trial = {1'b0, rs} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; done <= 1'b0; n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1; n_q <= 6'(W);
			end else if (busy_q) begin
				n_q <= n_q - 6'd1;
				if (n_q == 6'd1) begin
					busy_q <= 1'b0; done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= dividend[W-1] ? -dividend : dividend;
			d_q  <= divisor[W-1] ? -divisor : divisor;
			r_q  <= '0;
			nq_q <= dividend[W-1] ^ divisor[W-1];
			nr_q <= dividend[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quot = nq_q ? -q_q : q_q;
	assign rem  = nr_q ? -r_q : r_q;
endmodule

// ===== hw/rtl/fds_back.sv =====
// ----------------------------------------------------------------------------
// fds_back: stack execution engine
// reads operands from the store one per cycle, computes, writes back
// ----------------------------------------------------------------------------
module fds_back #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [fds_pkg::COUNT_W-1:0]       stack_limit,
	input  logic                              q_valid,
	input  fds_pkg::front_item_t              q_item,
	output logic                              q_take,
	output logic                              res_valid,
	input  logic                              res_take,
	output logic [fds_pkg::STATUS_W-1:0]      res_status,
	output logic [fds_pkg::WORD_W-1:0]        res_top,
	output logic [fds_pkg::COUNT_W-1:0]       res_depth,
	output logic                              idle
);
	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned W  = fds_pkg::WORD_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_READ  = 7'b0000010,
		S_CALC  = 7'b0000100,
		S_WAIT  = 7'b0001000,
		S_WRITE = 7'b0010000,
		S_TOP   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [W-1:0] mem [STACK_DEPTH];
	logic [W-1:0] rd_data_q;
	logic [CW-1:0] count_q, base_q;
	fds_pkg::front_item_t it_q;
	logic [W-1:0] x_q [4];
	logic [W-1:0] o_q [6];
	logic [2:0]   k_q;
	logic         rd_pend_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [W-1:0]  wr_data;
	logic [CW-1:0] lim;
	logic [CW:0]   grown;
	logic [W-1:0]  prod_s1;
	logic          div_start, div_done;
	logic [W-1:0]  div_q, div_r;
	logic [W-1:0]  alu;
	logic          drop_sel_q;

	// effective limit: min(stack_limit, STACK_DEPTH)
	always_comb begin
		if ({{(CW+1){1'b0}}, stack_limit} > (CW+1+7)'(STACK_DEPTH)) lim = CW'(STACK_DEPTH);
		else lim = CW'(stack_limit);
	end
	assign grown = {1'b0, count_q} + (CW+1)'(q_item.grow_up);

	fds_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(x_q[0]), .divisor(x_q[1]),
		.done(div_done), .quot(div_q), .rem(div_r)
	);

	always_comb begin
		case (it_q.action)
			fds_pkg::ACT_ADD: alu = x_q[0] + x_q[1];
			fds_pkg::ACT_SUB: alu = x_q[0] - x_q[1];
			fds_pkg::ACT_EQ:  alu = (x_q[0] == x_q[1]) ? '1 : '0;
			fds_pkg::ACT_LT:  alu = ($signed(x_q[0]) < $signed(x_q[1])) ? '1 : '0;
			fds_pkg::ACT_GT:  alu = ($signed(x_q[0]) > $signed(x_q[1])) ? '1 : '0;
			default:          alu = (x_q[0] == '1) ? '0 : '1;
		endcase
	end

	assign div_start = (state_q == S_CALC) && (it_q.op_class == fds_pkg::CLS_DIV);
	assign idle      = (state_q == S_IDLE) && !q_valid && !res_valid;
	assign q_take    = (state_q == S_IDLE) && q_valid && !res_valid;

	always_comb begin
		rd_addr = '0;
		if (state_q == S_READ) rd_addr = AW'(base_q + CW'(k_q));
		else rd_addr = AW'(count_q - CW'(1));
		wr_en   = (state_q == S_WRITE) && (k_q < it_q.nout);
		wr_addr = AW'(base_q + CW'(k_q));
		wr_data = o_q[k_q];
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= x_q[0] * x_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; count_q <= '0; res_valid <= 1'b0;
			k_q <= '0; rd_pend_q <= 1'b0; drop_sel_q <= 1'b0;
		end else begin
			if (res_valid && res_take) res_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid && !res_valid) begin
						it_q <= q_item;
						res_depth <= fds_pkg::COUNT_W'(count_q);
						base_q <= count_q - CW'(q_item.need);
						k_q <= '0; rd_pend_q <= 1'b0; drop_sel_q <= 1'b0;
						if (!q_item.known) begin
							res_status <= fds_pkg::ST_OK;
							state_q <= S_TOP;
						end else if (count_q < CW'(q_item.need)) begin
							res_status <= fds_pkg::ST_UNDER;
							state_q <= S_TOP;
						end else if (q_item.grow_up != 3'd0 && grown > {1'b0, lim}) begin
							res_status <= fds_pkg::ST_OVER;
							state_q <= S_TOP;
						end else begin
							res_status <= fds_pkg::ST_OK;
							state_q <= (q_item.need == 3'd0) ? S_CALC : S_READ;
						end
					end
				end
				S_READ: begin
					// address issued this cycle, data lands next cycle
					if (rd_pend_q) x_q[2'(k_q - 3'd1)] <= rd_data_q;
					if (k_q < it_q.need) begin
						k_q <= k_q + 3'd1; rd_pend_q <= 1'b1;
					end else begin
						k_q <= '0; rd_pend_q <= 1'b0;
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (it_q.op_class == fds_pkg::CLS_DIV && x_q[1] == '0) begin
						res_status <= fds_pkg::ST_DIVZ;
						state_q <= S_TOP;
					end else begin
						case (it_q.action)
							fds_pkg::ACT_PUSH: o_q[0] <= it_q.push_value;
							fds_pkg::ACT_DROP: begin
								res_top <= x_q[0]; drop_sel_q <= 1'b1;
							end
							fds_pkg::ACT_PEEK: o_q[0] <= x_q[0];
							fds_pkg::ACT_DUP: begin o_q[0] <= x_q[0]; o_q[1] <= x_q[0]; end
							fds_pkg::ACT_SWAP: begin o_q[0] <= x_q[1]; o_q[1] <= x_q[0]; end
							fds_pkg::ACT_OVER: begin
								o_q[0] <= x_q[0]; o_q[1] <= x_q[1]; o_q[2] <= x_q[0];
							end
							fds_pkg::ACT_ROT: begin
								o_q[0] <= x_q[1]; o_q[1] <= x_q[2]; o_q[2] <= x_q[0];
							end
							fds_pkg::ACT_2SWAP: begin
								o_q[0] <= x_q[2]; o_q[1] <= x_q[3];
								o_q[2] <= x_q[0]; o_q[3] <= x_q[1];
							end
							fds_pkg::ACT_2DUP: begin
								o_q[0] <= x_q[0]; o_q[1] <= x_q[1];
								o_q[2] <= x_q[0]; o_q[3] <= x_q[1];
							end
							fds_pkg::ACT_2OVER: begin
								o_q[0] <= x_q[0]; o_q[1] <= x_q[1]; o_q[2] <= x_q[2];
								o_q[3] <= x_q[3]; o_q[4] <= x_q[0]; o_q[5] <= x_q[1];
							end
							default: o_q[0] <= alu;
						endcase
						state_q <= (it_q.op_class == fds_pkg::CLS_MUL ||
							it_q.op_class == fds_pkg::CLS_DIV) ? S_WAIT : S_WRITE;
					end
				end
				S_WAIT: begin
					if (it_q.op_class == fds_pkg::CLS_MUL) begin
						o_q[0] <= prod_s1; state_q <= S_WRITE;
					end else if (div_done) begin
						if (it_q.action == fds_pkg::ACT_DIV) o_q[0] <= div_q;
						else if (it_q.action == fds_pkg::ACT_MOD) o_q[0] <= div_r;
						else begin o_q[0] <= div_r; o_q[1] <= div_q; end
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (k_q < it_q.nout) k_q <= k_q + 3'd1;
					else begin
						count_q <= base_q + CW'(it_q.nout);
						res_depth <= fds_pkg::COUNT_W'(base_q + CW'(it_q.nout));
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					// read of the current top issued now
					state_q <= S_OUT;
				end
				default: begin
					if (!drop_sel_q) res_top <= (count_q == '0) ? '0 : rd_data_q;
					res_valid <= 1'b1;
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
